// ===== rtl/core/lrip_pkg.sv =====
`default_nettype none

package lrip_pkg;

  // sizing limits of the image and the coordinate word
  localparam int MAX_ROWS    = 128;
  localparam int MAX_COLUMNS = 4096;
  localparam int COORD_BITS  = 20;

  // configuration registers
  localparam int ROW_CNT_W  = 8;
  localparam int COL_CNT_W  = 13;
  localparam int BOT_W      = 23;
  localparam int STEP_W     = 25;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT,
    REG_COLUMN_COUNT,
    REG_BOTTOM_ANGLE,
    REG_VERTICAL_STEP,
    REG_HORIZONTAL_STEP
  } cfg_reg_e;

  // result fields
  localparam int ROW_W       = 7;
  localparam int COLUMN_W    = 12;
  localparam int INDEX_W     = 19;
  localparam int RANGE_W     = 20;
  localparam int INTENSITY_W = 16;

  // square root
  localparam int RAD_W       = 2 * COORD_BITS;
  localparam int ROOT_W      = COORD_BITS;
  localparam int SQRT_STAGES = ROOT_W;

  // angles, 1/65536 degree
  localparam int ANG_ONE  = 65536;
  localparam int DEG90    = 90 * ANG_ONE;
  localparam int DEG180   = 180 * ANG_ONE;
  localparam int ANG_W    = 27;

  // atan2: normalize to [2^31, 2^32), then vectoring iterations
  localparam int ATAN_IN_W    = COORD_BITS + 1;
  localparam int NORM_W       = 32;
  localparam int SH_W         = $clog2(NORM_W);
  localparam int NORM_EXT_W   = (ATAN_IN_W > NORM_W) ? ATAN_IN_W : NORM_W;
  localparam int CORDIC_W     = NORM_EXT_W + 4;
  localparam int CORDIC_STEPS = 23;
  localparam int ATAN_STAGES  = CORDIC_STEPS + 2;

  localparam int ATAN_TAB [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
  };

  // divider
  localparam int DIV_NUM_W  = 39;
  localparam int DIV_STAGES = DIV_NUM_W;

endpackage

`default_nettype wire

// ===== rtl/core/lrip_if.sv =====
`default_nettype none

interface lrip_point_if;
  import lrip_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  pos_x;
  logic signed [COORD_BITS-1:0]  pos_y;
  logic signed [COORD_BITS-1:0]  pos_z;
  logic        [INTENSITY_W-1:0] intensity_in;

  modport source (output valid, pos_x, pos_y, pos_z, intensity_in, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, intensity_in, output ready);
endinterface

interface lrip_pixel_if;
  import lrip_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   pixel_valid;
  logic [ROW_W-1:0]       row_out;
  logic [COLUMN_W-1:0]    column_out;
  logic [INDEX_W-1:0]     pixel_index;
  logic [RANGE_W-1:0]     range_out;
  logic [INTENSITY_W-1:0] intensity_out;

  modport source (output valid, pixel_valid, row_out, column_out, pixel_index, range_out,
                  intensity_out, input ready);
  modport sink   (input valid, pixel_valid, row_out, column_out, pixel_index, range_out,
                  intensity_out, output ready);
endinterface

interface lrip_cfg_if;
  import lrip_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lrip_sqrt.sv =====
`default_nettype none

module lrip_sqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [lrip_pkg::RAD_W-1:0]   rad_i,
  output logic [lrip_pkg::ROOT_W-1:0]  root_o
);
  import lrip_pkg::*;

  logic [RAD_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];

  // one result bit per stage, most significant first
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  trial;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = (RAD_W'(root_in) << (B + 1)) | (RAD_W'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[k]  <= rem_in - trial;
          root_q[k] <= root_in | (ROOT_W'(1) << B);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/lrip_atan2.sv =====
`default_nettype none

module lrip_atan2 (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [lrip_pkg::ATAN_IN_W-1:0] num_i,
  input  logic signed [lrip_pkg::ATAN_IN_W-1:0] den_i,
  output logic signed [lrip_pkg::ANG_W-1:0]   ang_o
);
  import lrip_pkg::*;

  // normalize stage
  logic [ATAN_IN_W-1:0]  mag_n;
  logic [ATAN_IN_W-1:0]  mag_d;
  logic [ATAN_IN_W-1:0]  mag_m;
  logic [NORM_EXT_W-1:0] m_ext;
  logic [SH_W-1:0]       sh_d;

  logic signed [ATAN_IN_W-1:0] num_a_q;
  logic signed [ATAN_IN_W-1:0] den_a_q;
  logic [SH_W-1:0]             sh_a_q;
  logic                        zero_a_q;

  assign mag_n = num_i[ATAN_IN_W-1] ? ATAN_IN_W'(-num_i) : ATAN_IN_W'(num_i);
  assign mag_d = den_i[ATAN_IN_W-1] ? ATAN_IN_W'(-den_i) : ATAN_IN_W'(den_i);
  assign mag_m = (mag_n > mag_d) ? mag_n : mag_d;
  assign m_ext = NORM_EXT_W'(mag_m);

  always_comb begin
    sh_d = '0;
    for (int k = 0; k < NORM_W - 1; k++) begin
      if (m_ext[k]) sh_d = SH_W'(NORM_W - 1 - k);
    end
    if (|m_ext[NORM_EXT_W-1:NORM_W-1]) sh_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_a_q  <= num_i;
      den_a_q  <= den_i;
      sh_a_q   <= sh_d;
      zero_a_q <= (mag_m == '0);
    end
  end

  // scale and fold into the right half plane
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;

  logic signed [CORDIC_W-1:0] x_q  [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] y_q  [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0]    z_q  [CORDIC_STEPS+1];
  logic                       zr_q [CORDIC_STEPS+1];

  assign xs = CORDIC_W'(den_a_q) <<< sh_a_q;
  assign ys = CORDIC_W'(num_a_q) <<< sh_a_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zr_q[0] <= zero_a_q;
      if (xs[CORDIC_W-1]) begin
        x_q[0] <= -xs;
        y_q[0] <= -ys;
        z_q[0] <= ys[CORDIC_W-1] ? -ANG_W'(DEG180) : ANG_W'(DEG180);
      end else begin
        x_q[0] <= xs;
        y_q[0] <= ys;
        z_q[0] <= '0;
      end
    end
  end

  // vectoring iterations, drive y toward zero
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zr_q[i+1] <= zr_q[i];
        if (!y_q[i][CORDIC_W-1]) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ANG_W'(ATAN_TAB[i]);
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ANG_W'(ATAN_TAB[i]);
        end
      end
    end
  end

  // zero vector gives zero angle
  assign ang_o = zr_q[CORDIC_STEPS] ? '0 : z_q[CORDIC_STEPS];

endmodule

`default_nettype wire

// ===== rtl/core/lrip_div.sv =====
`default_nettype none

module lrip_div (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [lrip_pkg::DIV_NUM_W-1:0] num_i,
  input  logic        [lrip_pkg::STEP_W-1:0]    den_i,
  output logic signed [lrip_pkg::DIV_NUM_W-1:0] quo_o
);
  import lrip_pkg::*;

  logic [STEP_W-1:0]    rem_q [DIV_STAGES];
  logic [DIV_NUM_W-1:0] n_q   [DIV_STAGES];
  logic [DIV_NUM_W-1:0] q_q   [DIV_STAGES];
  logic                 neg_q [DIV_STAGES];

  // restoring division on magnitudes, one quotient bit per stage
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [STEP_W-1:0]    rem_in;
    logic [DIV_NUM_W-1:0] n_in;
    logic [DIV_NUM_W-1:0] q_in;
    logic                 neg_in;
    logic [STEP_W:0]      trial;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign n_in   = num_i[DIV_NUM_W-1] ? DIV_NUM_W'(-num_i) : DIV_NUM_W'(num_i);
      assign q_in   = '0;
      assign neg_in = num_i[DIV_NUM_W-1];
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign n_in   = n_q[k-1];
      assign q_in   = q_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    assign trial = {rem_in, n_in[DIV_NUM_W-1]};
    assign ge    = (trial >= {1'b0, den_i});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? STEP_W'(trial - {1'b0, den_i}) : STEP_W'(trial);
        n_q[k]   <= n_in << 1;
        q_q[k]   <= {q_in[DIV_NUM_W-2:0], ge};
        neg_q[k] <= neg_in;
      end
    end
  end

  // truncate toward zero
  assign quo_o = neg_q[DIV_STAGES-1] ? -$signed(q_q[DIV_STAGES-1])
                                     : $signed(q_q[DIV_STAGES-1]);

endmodule

`default_nettype wire

// ===== rtl/core/lidar_range_image_projection.sv =====
// Throughput: one point per cycle; set by the fully pipelined square roots,
// atan2 iterations and dividers, and the whole pipeline holds while the output stalls.
// Reset: asynchronous, active low; clears the valid bits of every stage and loads
// the default image geometry (16 rows, 1800 columns) into the configuration registers.
`default_nettype none

module lidar_range_image_projection (
  input  logic       clk_i,
  input  logic       rst_ni,
  lrip_point_if.sink   point_i,
  lrip_pixel_if.source pixel_o,
  lrip_cfg_if.sink     cfg_i
);
  import lrip_pkg::*;

  localparam int POS_DLY  = 2 + SQRT_STAGES;
  localparam int RNG_DLY  = ATAN_STAGES + 2 + DIV_STAGES + 2;
  localparam int INT_DLY  = POS_DLY + RNG_DLY;
  localparam int VLD_DLY  = INT_DLY + 1;
  localparam int PROD_W   = COL_CNT_W - 1 + STEP_W;
  localparam int HM_W     = ANG_W + 1;
  localparam int IDX_FULL = ROW_W + COL_CNT_W + 1;

  // configuration
  logic [ROW_CNT_W-1:0] row_count_q;
  logic [COL_CNT_W-1:0] column_count_q;
  logic [BOT_W-1:0]     bottom_angle_q;
  logic [STEP_W-1:0]    vertical_step_q;
  logic [STEP_W-1:0]    horizontal_step_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q       <= ROW_CNT_W'(16);
      column_count_q    <= COL_CNT_W'(1800);
      bottom_angle_q    <= BOT_W'(989594);
      vertical_step_q   <= STEP_W'(131072);
      horizontal_step_q <= STEP_W'(13107);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_ROW_COUNT:       row_count_q       <= cfg_i.data[ROW_CNT_W-1:0];
        REG_COLUMN_COUNT:    column_count_q    <= cfg_i.data[COL_CNT_W-1:0];
        REG_BOTTOM_ANGLE:    bottom_angle_q    <= cfg_i.data[BOT_W-1:0];
        REG_VERTICAL_STEP:   vertical_step_q   <= cfg_i.data[STEP_W-1:0];
        REG_HORIZONTAL_STEP: horizontal_step_q <= cfg_i.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  logic [ROW_CNT_W-1:0] rows_eff;
  logic [COL_CNT_W-1:0] cols_eff;
  logic [STEP_W-1:0]    vstep_eff;
  logic [STEP_W-1:0]    hstep_eff;

  assign rows_eff  = (row_count_q > ROW_CNT_W'(MAX_ROWS)) ? ROW_CNT_W'(MAX_ROWS) : row_count_q;
  assign cols_eff  = (column_count_q > COL_CNT_W'(MAX_COLUMNS)) ? COL_CNT_W'(MAX_COLUMNS)
                                                               : column_count_q;
  assign vstep_eff = (vertical_step_q == '0) ? STEP_W'(1) : vertical_step_q;
  assign hstep_eff = (horizontal_step_q == '0) ? STEP_W'(1) : horizontal_step_q;

  // pipeline control: every stage advances together
  logic               adv;
  logic               acc;
  logic [VLD_DLY-1:0] vld_q;

  assign adv           = !vld_q[VLD_DLY-1] || pixel_o.ready;
  assign point_i.ready = adv;
  assign acc           = point_i.valid && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[VLD_DLY-2:0], acc};
    end
  end

  // side data lines
  logic signed [COORD_BITS-1:0] px_q [POS_DLY];
  logic signed [COORD_BITS-1:0] py_q [POS_DLY];
  logic signed [COORD_BITS-1:0] pz_q [POS_DLY];
  logic [INTENSITY_W-1:0]       int_q [INT_DLY];
  logic [ROOT_W-1:0]            rng_q [RNG_DLY];
  logic [ROOT_W-1:0]            rxy;
  logic [ROOT_W-1:0]            rall;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q[0]  <= point_i.pos_x;
      py_q[0]  <= point_i.pos_y;
      pz_q[0]  <= point_i.pos_z;
      int_q[0] <= point_i.intensity_in;
      rng_q[0] <= rall;
      for (int k = 1; k < POS_DLY; k++) begin
        px_q[k] <= px_q[k-1];
        py_q[k] <= py_q[k-1];
        pz_q[k] <= pz_q[k-1];
      end
      for (int k = 1; k < INT_DLY; k++) int_q[k] <= int_q[k-1];
      for (int k = 1; k < RNG_DLY; k++) rng_q[k] <= rng_q[k-1];
    end
  end

  // squares and sums
  logic signed [COORD_BITS-1:0] ex;
  logic signed [COORD_BITS-1:0] ey;
  logic signed [COORD_BITS-1:0] ez;
  logic [RAD_W-1:0]             sqx_q;
  logic [RAD_W-1:0]             sqy_q;
  logic [RAD_W-1:0]             sqz_q;
  logic [RAD_W-1:0]             sq_xy_q;
  logic [RAD_W-1:0]             sq_all_q;

  assign ex = point_i.pos_x;
  assign ey = point_i.pos_y;
  assign ez = point_i.pos_z;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_q    <= RAD_W'(ex * ex);
      sqy_q    <= RAD_W'(ey * ey);
      sqz_q    <= RAD_W'(ez * ez);
      sq_xy_q  <= sqx_q + sqy_q;
      sq_all_q <= sqx_q + sqy_q + sqz_q;
    end
  end

  lrip_sqrt u_sqrt_xy (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (sq_xy_q),
    .root_o (rxy)
  );

  lrip_sqrt u_sqrt_all (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (sq_all_q),
    .root_o (rall)
  );

  // angles
  logic signed [ANG_W-1:0] vang;
  logic signed [ANG_W-1:0] hang;

  lrip_atan2 u_atan_v (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (ATAN_IN_W'(pz_q[POS_DLY-1])),
    .den_i ($signed({1'b0, rxy})),
    .ang_o (vang)
  );

  lrip_atan2 u_atan_h (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (ATAN_IN_W'(px_q[POS_DLY-1])),
    .den_i (ATAN_IN_W'(py_q[POS_DLY-1])),
    .ang_o (hang)
  );

  // numerators
  logic signed [DIV_NUM_W-1:0] rnum_a_q;
  logic signed [DIV_NUM_W-1:0] rnum_q;
  logic signed [DIV_NUM_W-1:0] cnum_q;
  logic [PROD_W-1:0]           prod_q;
  logic signed [HM_W-1:0]      hm_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rnum_a_q <= DIV_NUM_W'(vang)
                + $signed({{(DIV_NUM_W-BOT_W){1'b0}}, bottom_angle_q});
      prod_q   <= PROD_W'(cols_eff[COL_CNT_W-1:1]) * PROD_W'(hstep_eff);
      hm_q     <= HM_W'(hang) - HM_W'(DEG90);
      rnum_q   <= rnum_a_q;
      cnum_q   <= $signed({{(DIV_NUM_W-PROD_W){1'b0}}, prod_q}) - DIV_NUM_W'(hm_q);
    end
  end

  logic signed [DIV_NUM_W-1:0] row_quo;
  logic signed [DIV_NUM_W-1:0] col_quo;

  lrip_div u_div_row (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (rnum_q),
    .den_i (vstep_eff),
    .quo_o (row_quo)
  );

  lrip_div u_div_col (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (cnum_q),
    .den_i (hstep_eff),
    .quo_o (col_quo)
  );

  // wrap, range check and flat index
  logic signed [DIV_NUM_W-1:0] row1_q;
  logic signed [DIV_NUM_W-1:0] col1_q;
  logic signed [DIV_NUM_W-1:0] row2_q;
  logic signed [DIV_NUM_W-1:0] col2_q;
  logic signed [DIV_NUM_W-1:0] cols_s;
  logic signed [DIV_NUM_W-1:0] rows_s;
  logic                        pix_ok;
  logic [IDX_FULL-1:0]         idx_full;

  assign cols_s = $signed({{(DIV_NUM_W-COL_CNT_W){1'b0}}, cols_eff});
  assign rows_s = $signed({{(DIV_NUM_W-ROW_CNT_W){1'b0}}, rows_eff});

  assign pix_ok = !row2_q[DIV_NUM_W-1] && (row2_q < rows_s)
               && !col2_q[DIV_NUM_W-1] && (col2_q < cols_s);
  assign idx_full = IDX_FULL'(row2_q[ROW_W-1:0]) * IDX_FULL'(cols_eff)
                  + IDX_FULL'(col2_q[COLUMN_W-1:0]);

  logic                   pix_valid_q;
  logic [ROW_W-1:0]       row_out_q;
  logic [COLUMN_W-1:0]    col_out_q;
  logic [INDEX_W-1:0]     index_q;
  logic [RANGE_W-1:0]     range_q;
  logic [INTENSITY_W-1:0] inten_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      row1_q <= row_quo;
      col1_q <= col_quo;
      row2_q <= row1_q;
      // wrap once by the column count
      col2_q <= (col1_q >= cols_s) ? col1_q - cols_s : col1_q;
      pix_valid_q <= pix_ok;
      row_out_q   <= pix_ok ? row2_q[ROW_W-1:0] : '0;
      col_out_q   <= pix_ok ? col2_q[COLUMN_W-1:0] : '0;
      index_q     <= pix_ok ? idx_full[INDEX_W-1:0] : '0;
      range_q     <= RANGE_W'(rng_q[RNG_DLY-1]);
      inten_q     <= int_q[INT_DLY-1];
    end
  end

  assign pixel_o.valid         = vld_q[VLD_DLY-1];
  assign pixel_o.pixel_valid   = pix_valid_q;
  assign pixel_o.row_out       = row_out_q;
  assign pixel_o.column_out    = col_out_q;
  assign pixel_o.pixel_index   = index_q;
  assign pixel_o.range_out     = range_q;
  assign pixel_o.intensity_out = inten_q;

`ifndef NO_ASSERTIONS
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_o.valid && !pixel_o.pixel_valid |->
      pixel_o.row_out == '0 && pixel_o.column_out == '0 && pixel_o.pixel_index == '0)
    else $error("invalid pixel carries nonzero location");

  a_inside_image : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_o.valid && pixel_o.pixel_valid |->
      ROW_CNT_W'(pixel_o.row_out) < rows_eff && COL_CNT_W'(pixel_o.column_out) < cols_eff)
    else $error("valid pixel outside the image");

  a_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_o.valid && pixel_o.pixel_valid |->
      pixel_o.pixel_index == INDEX_W'(IDX_FULL'(pixel_o.row_out) * IDX_FULL'(cols_eff)
                                      + IDX_FULL'(pixel_o.column_out)))
    else $error("flat index does not match row and column");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lrip_pkg::*;

  localparam int  DRAIN_CYCLES = 120;
  localparam int  STALL_LIMIT  = 5000;
  localparam int  RANGE_SAT    = 1048575;

  typedef struct packed {
    logic                   pixel_valid;
    logic [ROW_W-1:0]       row_out;
    logic [COLUMN_W-1:0]    column_out;
    logic [INDEX_W-1:0]     pixel_index;
    logic [RANGE_W-1:0]     range_out;
    logic [INTENSITY_W-1:0] intensity_out;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lrip_point_if pt();
  lrip_pixel_if pix();
  lrip_cfg_if   cfg();

  lidar_range_image_projection u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .point_i(pt.sink),
    .pixel_o(pix.source),
    .cfg_i  (cfg.sink)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the image geometry
  logic [ROW_CNT_W-1:0] geo_rows  = 8'd16;
  logic [COL_CNT_W-1:0] geo_cols  = 13'd1800;
  logic [BOT_W-1:0]     geo_bot   = 23'd989594;
  logic [STEP_W-1:0]    geo_vstep = 25'd131072;
  logic [STEP_W-1:0]    geo_hstep = 25'd13107;

  pixel_t pending_pixels[$];
  int     errors = 0;
  int     points_sent = 0;
  int     pixels_seen = 0;
  int     valid_pixels = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     quiet_cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // vectoring rotation; angle of (den, num) in 1/65536 degree
  function automatic longint cordic_angle(longint num, longint den);
    longint unsigned m;
    longint x, y, z, dx, dy;
    int sh;
    m = ((num < 0) ? -num : num) > ((den < 0) ? -den : den) ?
        ((num < 0) ? -num : num) : ((den < 0) ? -den : den);
    if (m == 0) return 0;
    sh = 0;
    while (m < (64'd1 << 31)) begin
      m <<= 1;
      sh++;
    end
    x = den <<< sh;
    y = num <<< sh;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? DEG180 : -DEG180;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += ATAN_TAB[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic pixel_t project_point(logic signed [COORD_BITS-1:0] px,
                                           logic signed [COORD_BITS-1:0] py,
                                           logic signed [COORD_BITS-1:0] pz,
                                           logic [INTENSITY_W-1:0] inten);
    longint x, y, z, rxy, rows, cols, vs, hs, row, col;
    longint unsigned sq_xy, rng;
    logic ok;
    pixel_t p;
    x = px;
    y = py;
    z = pz;
    sq_xy = x * x + y * y;
    rxy = int_sqrt(sq_xy);
    rng = int_sqrt(sq_xy + z * z);
    rows = (geo_rows > MAX_ROWS) ? MAX_ROWS : geo_rows;
    cols = (geo_cols > MAX_COLUMNS) ? MAX_COLUMNS : geo_cols;
    vs = (geo_vstep == 0) ? 1 : geo_vstep;
    hs = (geo_hstep == 0) ? 1 : geo_hstep;
    row = (cordic_angle(z, rxy) + longint'(geo_bot)) / vs;
    col = ((cols / 2) * hs - (cordic_angle(x, y) - DEG90)) / hs;
    if (col >= cols) col -= cols;
    ok = row >= 0 && row < rows && col >= 0 && col < cols;
    p.pixel_valid   = ok;
    p.row_out       = ok ? row[ROW_W-1:0] : '0;
    p.column_out    = ok ? col[COLUMN_W-1:0] : '0;
    p.pixel_index   = ok ? INDEX_W'(col + row * cols) : '0;
    p.range_out     = RANGE_W'((rng > RANGE_SAT) ? RANGE_SAT : rng);
    p.intensity_out = inten;
    return p;
  endfunction

  initial begin
    pt.valid = 1'b0;
    pt.pos_x = '0;
    pt.pos_y = '0;
    pt.pos_z = '0;
    pt.intensity_in = '0;
    pix.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) pix.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each pixel word against the oldest prediction
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && pix.valid && pix.ready) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        $error("pixel word with no prediction pending");
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (want.pixel_valid) valid_pixels++;
        if (pix.pixel_valid !== want.pixel_valid) begin
          $error("pixel_valid exp %0d got %0d", want.pixel_valid, pix.pixel_valid);
          errors++;
        end
        if (pix.row_out !== want.row_out) begin
          $error("row_out exp %0d got %0d", want.row_out, pix.row_out);
          errors++;
        end
        if (pix.column_out !== want.column_out) begin
          $error("column_out exp %0d got %0d", want.column_out, pix.column_out);
          errors++;
        end
        if (pix.pixel_index !== want.pixel_index) begin
          $error("pixel_index exp %0d got %0d", want.pixel_index, pix.pixel_index);
          errors++;
        end
        if (pix.range_out !== want.range_out) begin
          $error("range_out exp %0d got %0d", want.range_out, pix.range_out);
          errors++;
        end
        if (pix.intensity_out !== want.intensity_out) begin
          $error("intensity_out exp %0d got %0d", want.intensity_out, pix.intensity_out);
          errors++;
        end
      end
    end
  end

  // abort if no channel moves a word for too long
  always @(posedge clk_i) begin
    if ((pt.valid && pt.ready) || (pix.valid && pix.ready) || (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL lidar_range_image_projection");
      $finish;
    end
  end

  task automatic send_point(int px, int py, int pz, int inten);
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] sz;
    logic [INTENSITY_W-1:0]       si;
    sx = COORD_BITS'(px);
    sy = COORD_BITS'(py);
    sz = COORD_BITS'(pz);
    si = INTENSITY_W'(inten);
    if ($urandom_range(99) < send_idle_pct) begin
      pt.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    pt.valid = 1'b1;
    pt.pos_x = sx;
    pt.pos_y = sy;
    pt.pos_z = sz;
    pt.intensity_in = si;
    do @(posedge clk_i); while (!pt.ready);
    pending_pixels.push_back(project_point(sx, sy, sz, si));
    points_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    pt.valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = value;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      REG_ROW_COUNT:       geo_rows  = value[ROW_CNT_W-1:0];
      REG_COLUMN_COUNT:    geo_cols  = value[COL_CNT_W-1:0];
      REG_BOTTOM_ANGLE:    geo_bot   = value[BOT_W-1:0];
      REG_VERTICAL_STEP:   geo_vstep = value[STEP_W-1:0];
      REG_HORIZONTAL_STEP: geo_hstep = value[STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  task automatic set_geometry(int rows, int cols, int bot, int vs, int hs);
    drain_pipeline();
    write_reg(REG_ROW_COUNT, CFG_DATA_W'(rows));
    write_reg(REG_COLUMN_COUNT, CFG_DATA_W'(cols));
    write_reg(REG_BOTTOM_ANGLE, CFG_DATA_W'(bot));
    write_reg(REG_VERTICAL_STEP, CFG_DATA_W'(vs));
    write_reg(REG_HORIZONTAL_STEP, CFG_DATA_W'(hs));
  endtask

  // mostly points at street distances so many land in the image
  task automatic send_random_point();
    int px, py, pz;
    if ($urandom_range(3) == 0) begin
      px = $urandom;
      py = $urandom;
      pz = $urandom;
    end else begin
      px = int'($urandom_range(60000)) - 30000;
      py = int'($urandom_range(60000)) - 30000;
      pz = int'($urandom_range(2000)) - 1000;
    end
    send_point(px, py, pz, $urandom);
  endtask

  task automatic test_directed_points();
    send_point(0, 0, 0, 16'h0000);
    send_point(0, 0, 1000, 16'hFFFF);
    send_point(0, 0, -1000, 16'h5A5A);
    send_point(2560, 0, 0, 16'h0001);
    send_point(-2560, 0, 0, 16'h8000);
    send_point(0, 2560, 0, 16'h1234);
    send_point(0, -2560, 0, 16'hABCD);
    send_point(0, -2560, -1, 16'h0F0F);
    send_point(-524288, -524288, -524288, 16'hFFFF);
    send_point(524287, 524287, 524287, 16'h0000);
    send_point(524287, -524288, 0, 16'h7FFF);
    send_point(-524288, 1, 524287, 16'h00FF);
    send_point(-1, -1, 0, 16'hFF00);
    send_point(1, -1, 1, 16'h3333);
    send_point(2560, 2560, 100, 16'hCCCC);
    send_point(-2560, 2560, -200, 16'h1111);
  endtask

  task automatic test_geometry_extremes();
    // clamped counts, zero steps
    set_geometry(255, 8191, 0, 0, 0);
    test_directed_points();
    // largest legal angles
    set_geometry(128, 4096, 8388607, 33554431, 33554431);
    test_directed_points();
    // empty image: every point invalid
    set_geometry(0, 0, 5898240, 23592960, 23592960);
    repeat (8) send_random_point();
    set_geometry(1, 1, 2949120, 23592960, 23592960);
    repeat (8) send_random_point();
  endtask

  task automatic test_random_stream(int n);
    int phase_len;
    phase_len = n / 4;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      repeat (phase_len) send_random_point();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_pause_until_empty();
    recv_stall_pct = 51;
    repeat (20) send_random_point();
    // hold the sender until every pixel word is back
    pt.valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (20) send_random_point();
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed_points();
    test_random_stream(120);
    test_geometry_extremes();
    set_geometry(64, 2048, 1625292, 26214, 11520);
    test_random_stream(200);
    test_pause_until_empty();
    set_geometry(32, 900, 1048576, 78643, 26214);
    test_random_stream(160);
    drain_pipeline();
    $display("Projected %0d points, %0d pixel words checked, %0d inside the image,",
             points_sent, pixels_seen, valid_pixels);
    $display("across default, clamped, zero-step, empty and typical geometries.");
    if (errors == 0) begin
      $display("PASS lidar_range_image_projection");
    end else begin
      $display("FAIL lidar_range_image_projection");
    end
    $finish;
  end

endmodule

`default_nettype wire
